@@ src/stretch_overlay_rgb_composer_defines.svh @@
// ----------------------------------------------------------------------------
// stretch_overlay_rgb_composer_defines
// Assertion macros used by the checker file of the composer.
// ----------------------------------------------------------------------------
`ifndef STRETCH_OVERLAY_RGB_COMPOSER_DEFINES_SVH
`define STRETCH_OVERLAY_RGB_COMPOSER_DEFINES_SVH

// Property checked only outside reset.
`define SORC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define SORC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/sorc_pkg.sv @@
// ----------------------------------------------------------------------------
// sorc_pkg
// Types and constants of the stretch / overlay / RGB composer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sorc_pkg;

    localparam int GRAPHICS_LEVELS = 16;
    localparam int LEVEL_W         = 8;
    localparam int INDEX_W         = 4;
    localparam int QUO_W           = 8;
    localparam int REM_W           = 16;
    localparam int CFG_ADDR_W      = 2;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_ZERO    = 8'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_OVERLAY = 8'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_GFX_TOP = 8'(GRAPHICS_LEVELS);
    localparam logic [LEVEL_W-1:0] LEVEL_IMG_MIN = 8'(GRAPHICS_LEVELS + 1);

    localparam logic ACT_COMPOSE = 1'b0;
    localparam logic ACT_PALETTE = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] CFG_STRETCH_LOW  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STRETCH_HIGH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_OVERLAY_EN   = 2'd2;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [LEVEL_W-1:0] stretch_low;
        logic [LEVEL_W-1:0] stretch_high;
        logic               overlay_en;
    } t_cfg;

    // Sideband that rides along the divider chain untouched
    typedef struct packed {
        logic               action;
        logic               need_div;
        logic [LEVEL_W-1:0] fixed_level;
        logic [INDEX_W-1:0] entry_index;
        t_rgb               entry;
    } t_side;

    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [LEVEL_W-1:0] den;
        logic [QUO_W-1:0]   quo;
    } t_div;

    typedef struct packed {
        t_side side;
        t_div  div;
    } t_cellw;

endpackage

`default_nettype wire

@@ src/stretch_overlay_rgb_composer.sv @@
// ----------------------------------------------------------------------------
// stretch_overlay_rgb_composer
// Contrast stretch, overlay and palette lookup, one pixel item per clock while the output does not stall.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser action, tdata pixel+palette
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata composed RGB
// cfg       in   i_cfg_valid/o_cfg_ready        i_cfg_addr, i_cfg_data
//
// One item per clock sustained while the output does not stall; the chain is an entry cell, eight
// restoring-divider cells (one quotient bit each) and a color/output cell.
// Every cell holds its own item, so bubbles close up under output stall.
// Palette writes pass down the chain and land in the last cell, in order.
// Synchronous active-low reset clears control and loads register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stretch_overlay_rgb_composer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [7:0] pixel_level, [15:8] overlay_level, [19:16] entry_index,
    // [27:20] entry_red, [35:28] entry_green, [43:36] entry_blue, [47:44] zero
    input  wire logic [47:0]                       s_axis_tdata,
    // [0] action
    input  wire logic [0:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [7:0] out_red, [15:8] out_green, [23:16] out_blue
    output logic [23:0]                            m_axis_tdata,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [sorc_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [7:0]                        i_cfg_data
);

    localparam int DIV_CELLS = sorc_pkg::QUO_W;

    sorc_pkg::t_cfg   r_cfg;
    sorc_pkg::t_rgb   entry;
    sorc_pkg::t_rgb   out_rgb;
    sorc_pkg::t_cellw chain_data  [DIV_CELLS + 1];
    logic             chain_valid [DIV_CELLS + 1];
    logic             chain_ready [DIV_CELLS + 1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stretch_low  <= sorc_pkg::LEVEL_ZERO;
            r_cfg.stretch_high <= sorc_pkg::LEVEL_MAX;
            r_cfg.overlay_en   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_addr)
                sorc_pkg::CFG_STRETCH_LOW:  r_cfg.stretch_low  <= i_cfg_data;
                sorc_pkg::CFG_STRETCH_HIGH: r_cfg.stretch_high <= i_cfg_data;
                sorc_pkg::CFG_OVERLAY_EN:   r_cfg.overlay_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign entry = '{red:   s_axis_tdata[27:20],
                     green: s_axis_tdata[35:28],
                     blue:  s_axis_tdata[43:36]};

    sorc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_action  (s_axis_tuser[0]),
        .i_pixel   (s_axis_tdata[7:0]),
        .i_overlay (s_axis_tdata[15:8]),
        .i_index   (s_axis_tdata[19:16]),
        .i_entry   (entry),
        .i_cfg     (r_cfg),
        .o_valid   (chain_valid[0]),
        .i_ready   (chain_ready[0]),
        .o_data    (chain_data[0])
    );

    // Cell k resolves quotient bit QUO_W-1-k, MSB first
    for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
        sorc_div_cell #(
            .BIT (DIV_CELLS - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[k]),
            .o_ready (chain_ready[k]),
            .i_data  (chain_data[k]),
            .o_valid (chain_valid[k + 1]),
            .i_ready (chain_ready[k + 1]),
            .o_data  (chain_data[k + 1])
        );
    end

    sorc_color u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chain_valid[DIV_CELLS]),
        .o_ready (chain_ready[DIV_CELLS]),
        .i_data  (chain_data[DIV_CELLS]),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rgb   (out_rgb)
    );

    assign m_axis_tdata = {out_rgb.blue, out_rgb.green, out_rgb.red};

endmodule

`default_nettype wire

@@ src/sorc_front.sv @@
// ----------------------------------------------------------------------------
// sorc_front
// Entry cell: classifies the level, applies overlay, sets up the division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorc_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_action,
    input  wire logic [sorc_pkg::LEVEL_W-1:0] i_pixel,
    input  wire logic [sorc_pkg::LEVEL_W-1:0] i_overlay,
    input  wire logic [sorc_pkg::INDEX_W-1:0] i_index,
    input  wire sorc_pkg::t_rgb              i_entry,
    input  wire sorc_pkg::t_cfg              i_cfg,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output sorc_pkg::t_cellw                 o_data
);

    logic                         r_valid;
    sorc_pkg::t_cellw             r_data;
    sorc_pkg::t_cellw             n_data;
    logic [sorc_pkg::LEVEL_W-1:0] diff;

    assign o_ready = !r_valid || i_ready;
    assign diff    = i_pixel - i_cfg.stretch_low;

    always_comb begin
        n_data                  = '0;
        n_data.side.action      = i_action;
        n_data.side.entry_index = i_index;
        n_data.side.entry       = i_entry;
        // 255 * diff as (diff << 8) - diff
        n_data.div.rem = {diff, 8'h00} - {8'h00, diff};
        n_data.div.den = i_cfg.stretch_high - i_cfg.stretch_low;
        priority if (i_cfg.overlay_en && (i_overlay != sorc_pkg::LEVEL_ZERO)) begin
            n_data.side.fixed_level = sorc_pkg::LEVEL_OVERLAY;
        end else if (i_pixel <= sorc_pkg::LEVEL_GFX_TOP) begin
            n_data.side.fixed_level = i_pixel;
        end else if (i_pixel >= i_cfg.stretch_high) begin
            n_data.side.fixed_level = sorc_pkg::LEVEL_MAX;
        end else if (i_pixel <= i_cfg.stretch_low) begin
            n_data.side.fixed_level = sorc_pkg::LEVEL_ZERO;
        end else begin
            n_data.side.need_div = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

@@ src/sorc_div_cell.sv @@
// ----------------------------------------------------------------------------
// sorc_div_cell
// One restoring-division cell: resolves quotient bit BIT.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorc_div_cell #(
    parameter int BIT = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire sorc_pkg::t_cellw i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output sorc_pkg::t_cellw      o_data
);

    logic                       r_valid;
    sorc_pkg::t_cellw           r_data;
    sorc_pkg::t_cellw           n_data;
    logic [sorc_pkg::REM_W-1:0] den_sh;

    assign o_ready = !r_valid || i_ready;
    assign den_sh  = {{(sorc_pkg::REM_W - sorc_pkg::LEVEL_W){1'b0}}, i_data.div.den} << BIT;

    always_comb begin
        n_data = i_data;
        if (i_data.div.rem >= den_sh) begin
            n_data.div.rem      = i_data.div.rem - den_sh;
            n_data.div.quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

@@ src/sorc_color.sv @@
// ----------------------------------------------------------------------------
// sorc_color
// Last cell: palette store, level to RGB mapping and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorc_color (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire sorc_pkg::t_cellw i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output sorc_pkg::t_rgb        o_rgb
);

    logic                         r_valid;
    sorc_pkg::t_rgb               r_rgb;
    sorc_pkg::t_rgb               n_rgb;
    sorc_pkg::t_rgb               r_palette [sorc_pkg::GRAPHICS_LEVELS];
    logic [sorc_pkg::LEVEL_W-1:0] level;
    logic [sorc_pkg::INDEX_W-1:0] rd_index;
    logic                         load;
    logic                         is_write;

    assign o_ready  = !r_valid || i_ready;
    assign load     = o_ready && i_valid;
    assign is_write = (i_data.side.action == sorc_pkg::ACT_PALETTE);

    always_comb begin
        if (!i_data.side.need_div) begin
            level = i_data.side.fixed_level;
        end else if (i_data.div.quo < sorc_pkg::LEVEL_IMG_MIN) begin
            level = sorc_pkg::LEVEL_IMG_MIN;
        end else begin
            level = i_data.div.quo;
        end
    end

    assign rd_index = sorc_pkg::INDEX_W'(level - 8'd1);

    always_comb begin
        if ((level != sorc_pkg::LEVEL_ZERO) && (level <= sorc_pkg::LEVEL_GFX_TOP)) begin
            n_rgb = r_palette[rd_index];
        end else begin
            n_rgb = '{red: level, green: level, blue: level};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            // palette writes are consumed here and give no result
            r_valid <= i_valid && !is_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !is_write) begin
            r_rgb <= n_rgb;
        end
    end

    // Every 4-bit index addresses a real entry
    always_ff @(posedge i_clk) begin
        if (load && is_write) begin
            r_palette[i_data.side.entry_index] <= i_data.side.entry;
        end
    end

    assign o_valid = r_valid;
    assign o_rgb   = r_rgb;

endmodule

`default_nettype wire

@@ src/sorc_checker.sv @@
// ----------------------------------------------------------------------------
// sorc_checker
// Port-level assertions for the composer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "stretch_overlay_rgb_composer_defines.svh"

module sorc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);

    // Reset empties the output register
    `SORC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

    // A stalled result holds its value
    `SORC_ASSERT(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

    // With the output side free, the whole cell chain can move
    `SORC_ASSERT(a_in_ready, i_clk, i_rst_n, (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready, "input stalled while output free")

endmodule

bind stretch_overlay_rgb_composer sorc_checker u_sorc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stretch / overlay / RGB composer. A short
// scripted sequence covers blank, graphics and image levels, palette loads,
// overlay painting and crossed or equal stretch bounds. Random phases follow
// under several stretch settings, with bursty input and a stalling output.
// Each composed pixel is checked per channel against an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import sorc_pkg::*;

    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 30;   // cell chain plus margin for palette loads
    localparam int HOLD_CYCLES   = 250;
    localparam int STALL_LIMIT   = 5000;
    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = 225;

    typedef struct packed {
        logic               action;
        logic [LEVEL_W-1:0] pixel;
        logic [LEVEL_W-1:0] overlay;
        logic [INDEX_W-1:0] index;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } t_pix_item;

    typedef enum {STEP_ITEM, STEP_REG} t_step_kind;

    typedef struct {
        t_step_kind              kind;
        t_pix_item               it;
        bit                      typed;
        t_rgb                    want;
        logic [CFG_ADDR_W-1:0]   reg_addr;
        logic [7:0]              reg_val;
    } t_step;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [47:0]           s_axis_tdata;
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [23:0]           m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [7:0]            i_cfg_data;

    // predictor state
    logic [LEVEL_W-1:0] st_low;
    logic [LEVEL_W-1:0] st_high;
    logic               ovl_en;
    t_rgb               pal_mem [GRAPHICS_LEVELS];
    bit                 pal_loaded [GRAPHICS_LEVELS];
    t_rgb               rgb_due [$];

    t_step script [$];
    bit    hold_req;
    int    n_errors;
    int    n_items;
    int    n_loads;
    int    n_results;
    int    n_reg_writes;
    int    idle_cycles;

    stretch_overlay_rgb_composer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [LEVEL_W-1:0] stretched_level(logic [LEVEL_W-1:0] v);
        int q;
        if (v <= LEVEL_GFX_TOP) return v;
        if (v >= st_high) return LEVEL_MAX;   // end test wins when bounds cross
        if (v <= st_low) return LEVEL_ZERO;
        q = (255 * (int'(v) - int'(st_low))) / (int'(st_high) - int'(st_low));
        if (q < int'(LEVEL_IMG_MIN)) q = int'(LEVEL_IMG_MIN);
        return 8'(q);
    endfunction

    function automatic logic [LEVEL_W-1:0] shown_level(t_pix_item it);
        logic [LEVEL_W-1:0] lvl;
        lvl = stretched_level(it.pixel);
        if (ovl_en && it.overlay != 0) lvl = LEVEL_OVERLAY;
        return lvl;
    endfunction

    function automatic t_rgb composed_rgb(t_pix_item it);
        logic [LEVEL_W-1:0] lvl;
        lvl = shown_level(it);
        if (lvl >= 1 && lvl <= LEVEL_GFX_TOP) return pal_mem[lvl - 1];
        return '{red: lvl, green: lvl, blue: lvl};
    endfunction

    function automatic logic [7:0] edgy_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_pix_item random_item();
        t_pix_item          it;
        logic [LEVEL_W-1:0] lvl;
        int                 near_lvl;
        it.action  = ACT_COMPOSE;
        it.pixel   = 8'($urandom);
        it.overlay = 8'($urandom);
        it.index   = 4'($urandom);
        it.red     = edgy_byte();
        it.green   = edgy_byte();
        it.blue    = edgy_byte();
        if ($urandom_range(0, 99) < 20) begin
            it.action = ACT_PALETTE;
            return it;
        end
        case ($urandom_range(0, 9))
            0: it.pixel = LEVEL_ZERO;
            1, 2: it.pixel = 8'($urandom_range(1, GRAPHICS_LEVELS));
            3: it.pixel = LEVEL_IMG_MIN;
            4: it.pixel = LEVEL_MAX;
            5, 6: begin
                near_lvl = ($urandom_range(0, 1) ? int'(st_low) : int'(st_high))
                           + int'($urandom_range(0, 4)) - 2;
                if (near_lvl < 0) near_lvl = 0;
                if (near_lvl > 255) near_lvl = 255;
                it.pixel = 8'(near_lvl);
            end
            default: ;
        endcase
        case ($urandom_range(0, 3))
            0, 1: it.overlay = 8'h00;
            2: it.overlay = 8'($urandom_range(1, 255));
            default: it.overlay = 8'(1 << $urandom_range(0, 7));
        endcase
        // never look up a palette entry that has not been loaded yet
        lvl = shown_level(it);
        if (lvl >= 1 && lvl <= LEVEL_GFX_TOP && !pal_loaded[lvl - 1]) begin
            it.pixel   = LEVEL_ZERO;
            it.overlay = 8'h00;
        end
        return it;
    endfunction

    function automatic t_step blank_step();
        t_step s;
        s.kind     = STEP_ITEM;
        s.it       = '0;
        s.typed    = 1'b0;
        s.want     = '0;
        s.reg_addr = '0;
        s.reg_val  = '0;
        return s;
    endfunction

    function automatic void add_pixel(logic [7:0] p, logic [7:0] o);
        t_step s;
        s = blank_step();
        s.it.action  = ACT_COMPOSE;
        s.it.pixel   = p;
        s.it.overlay = o;
        script.push_back(s);
    endfunction

    function automatic void add_pixel_is(logic [7:0] p, logic [7:0] o,
                                         logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_step s;
        s = blank_step();
        s.it.action  = ACT_COMPOSE;
        s.it.pixel   = p;
        s.it.overlay = o;
        s.typed      = 1'b1;
        s.want       = '{red: r, green: g, blue: b};
        script.push_back(s);
    endfunction

    function automatic void add_entry(logic [3:0] idx, logic [7:0] r, logic [7:0] g,
                                      logic [7:0] b);
        t_step s;
        s = blank_step();
        s.it.action = ACT_PALETTE;
        s.it.index  = idx;
        s.it.red    = r;
        s.it.green  = g;
        s.it.blue   = b;
        script.push_back(s);
    endfunction

    function automatic void add_reg(logic [CFG_ADDR_W-1:0] addr, logic [7:0] val);
        t_step s;
        s = blank_step();
        s.kind     = STEP_REG;
        s.reg_addr = addr;
        s.reg_val  = val;
        script.push_back(s);
    endfunction

    // Entered and left at a falling edge; the predictor follows the accepted item.
    task automatic offer(t_pix_item it, bit typed = 1'b0, t_rgb want = '0);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.action;
        s_axis_tdata  <= {4'b0, it.blue, it.green, it.red, it.index, it.overlay, it.pixel};
        do @(posedge i_clk); while (!s_axis_tready);
        n_items++;
        if (it.action == ACT_PALETTE) begin
            pal_mem[it.index]    = '{red: it.red, green: it.green, blue: it.blue};
            pal_loaded[it.index] = 1'b1;
            n_loads++;
        end else begin
            rgb_due.push_back(typed ? want : composed_rgb(it));
        end
        @(negedge i_clk);
    endtask

    // Stop sending, wait for every pending pixel, then let palette loads drain.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (rgb_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        n_reg_writes++;
        case (addr)
            CFG_STRETCH_LOW:  st_low  = val;
            CFG_STRETCH_HIGH: st_high = val;
            CFG_OVERLAY_EN:   ovl_en  = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Receiver: rotating stall patterns, plus one long hold-off on request.
    initial begin
        int tick;
        tick = 0;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            tick++;
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                case ((tick / 101) % 4)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 99) < 75);
                    2: m_axis_tready <= (tick % 2 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 99) < 20);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (rgb_due.size() == 0) begin
                $error("pixel %h came out with nothing pending", m_axis_tdata);
                n_errors++;
            end else begin
                want = rgb_due.pop_front();
                n_results++;
                if (m_axis_tdata[7:0] !== want.red) begin
                    $error("out_red: expected %0d, actual %0d", want.red, m_axis_tdata[7:0]);
                    n_errors++;
                end
                if (m_axis_tdata[15:8] !== want.green) begin
                    $error("out_green: expected %0d, actual %0d",
                           want.green, m_axis_tdata[15:8]);
                    n_errors++;
                end
                if (m_axis_tdata[23:16] !== want.blue) begin
                    $error("out_blue: expected %0d, actual %0d",
                           want.blue, m_axis_tdata[23:16]);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: counts cycles without any handshake on any channel.
    initial begin
        idle_cycles = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        int                 gap;
        int                 burst;
        logic [LEVEL_W-1:0] lo;
        logic [LEVEL_W-1:0] hi;
        logic               ov;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        hold_req      = 1'b0;
        st_low        = LEVEL_ZERO;
        st_high       = LEVEL_MAX;
        ovl_en        = 1'b0;
        n_errors      = 0;
        n_items       = 0;
        n_loads       = 0;
        n_results     = 0;
        n_reg_writes  = 0;
        for (int i = 0; i < GRAPHICS_LEVELS; i++) begin
            pal_mem[i]    = '0;
            pal_loaded[i] = 1'b0;
        end

        // reset defaults: blank, top, first image level, identity stretch
        add_pixel_is(8'd0,   8'h00, 8'd0,   8'd0,   8'd0);
        add_pixel_is(8'd255, 8'h00, 8'd255, 8'd255, 8'd255);
        add_pixel_is(8'd17,  8'h00, 8'd17,  8'd17,  8'd17);
        add_pixel_is(8'd200, 8'h55, 8'd200, 8'd200, 8'd200);
        add_entry(4'd0,  8'hFF, 8'h00, 8'hFF);
        add_entry(4'd15, 8'h00, 8'hFF, 8'h00);
        add_entry(4'd2,  8'h12, 8'h34, 8'h56);
        add_entry(4'd7,  8'hA5, 8'h5A, 8'hC3);
        add_pixel_is(8'd1,  8'h00, 8'hFF, 8'h00, 8'hFF);
        add_pixel_is(8'd16, 8'h00, 8'h00, 8'hFF, 8'h00);
        add_pixel_is(8'd3,  8'hFF, 8'h12, 8'h34, 8'h56);
        add_pixel_is(8'd8,  8'h00, 8'hA5, 8'h5A, 8'hC3);
        // overlay paints level 3, only for a nonzero overlay pixel
        add_reg(CFG_OVERLAY_EN, 8'd1);
        add_pixel_is(8'd0,   8'hFF, 8'h12, 8'h34, 8'h56);
        add_pixel_is(8'd255, 8'h01, 8'h12, 8'h34, 8'h56);
        add_pixel_is(8'd16,  8'h00, 8'h00, 8'hFF, 8'h00);
        // crossed bounds: at or above the end gives 255, all other image levels 0
        add_reg(CFG_STRETCH_LOW,  8'd100);
        add_reg(CFG_STRETCH_HIGH, 8'd50);
        add_pixel_is(8'd60, 8'h00, 8'd255, 8'd255, 8'd255);
        add_pixel_is(8'd40, 8'h00, 8'd0,   8'd0,   8'd0);
        add_pixel_is(8'd50, 8'h00, 8'd255, 8'd255, 8'd255);
        // real stretch, including the clamp just above the start
        add_reg(CFG_STRETCH_HIGH, 8'd200);
        add_reg(CFG_OVERLAY_EN,   8'd0);
        add_pixel(8'd101, 8'h00);
        add_pixel(8'd199, 8'h07);
        add_pixel(8'd150, 8'h00);
        add_pixel_is(8'd100, 8'h00, 8'd0,   8'd0,   8'd0);
        add_pixel_is(8'd200, 8'h00, 8'd255, 8'd255, 8'd255);
        // equal bounds at the top
        add_reg(CFG_STRETCH_LOW,  8'd255);
        add_reg(CFG_STRETCH_HIGH, 8'd255);
        add_pixel_is(8'd254, 8'h00, 8'd0,   8'd0,   8'd0);
        add_pixel_is(8'd255, 8'h00, 8'd255, 8'd255, 8'd255);

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == STEP_REG) begin
                settle();
                write_reg(script[i].reg_addr, script[i].reg_val);
            end else begin
                offer(script[i].it, script[i].typed, script[i].want);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin lo = 8'd0;   hi = 8'd255; ov = 1'b0; end
                1: begin lo = 8'd0;   hi = 8'd255; ov = 1'b1; end
                2: begin lo = 8'd255; hi = 8'd0;   ov = 1'b1; end
                3: begin lo = 8'd255; hi = 8'd255; ov = 1'b0; end
                4: begin lo = 8'd0;   hi = 8'd0;   ov = 1'b1; end
                5: begin lo = 8'd30;  hi = 8'd40;  ov = 1'b0; end
                default: begin
                    lo = 8'($urandom_range(0, 200));
                    hi = 8'($urandom_range(lo, 255));
                    ov = 1'($urandom_range(0, 1));
                end
            endcase
            settle();
            write_reg(CFG_STRETCH_LOW,  lo);
            write_reg(CFG_STRETCH_HIGH, hi);
            write_reg(CFG_OVERLAY_EN,   {7'd0, ov});
            if (p == 1) hold_req = 1'b1;   // output holds off while input keeps coming
            burst = 0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 5 && k == PHASE_ITEMS / 2) settle();
                if (burst == 0) begin
                    burst = $urandom_range(1, 48);
                    if (p == 1 && k < 60) gap = 0;
                    else gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    if (gap > 0) begin
                        s_axis_tvalid <= 1'b0;
                        repeat (gap) @(negedge i_clk);
                    end
                end
                offer(random_item());
                burst--;
            end
        end

        settle();
        $display("Sent %0d items (%0d palette loads); checked %0d composed pixels.",
                 n_items, n_loads, n_results);
        $display("Made %0d register writes across %0d stretch/overlay settings.",
                 n_reg_writes, N_PHASES + 5);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
